>>> hw/rtl/contrast_stretch_core_macros.svh
// contrast_stretch_core_macros.svh
// Assertion helpers shared by the contrast stretch RTL.
`ifndef CONTRAST_STRETCH_CORE_MACROS_SVH
`define CONTRAST_STRETCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contrast stretch: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contrast stretch: next-cycle check failed");

`endif

>>> hw/rtl/cs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_pkg: contrast stretch types and constants
// Transaction payloads, controller/datapath command and status groups,
// function codes and the fixed constants of the min/max stretch.
// ----------------------------------------------------------------------------
package cs_pkg;

  localparam int          PIX_W      = 8;
  localparam int          DIV_STEPS  = PIX_W;
  localparam int          CNT_W      = $clog2(DIV_STEPS);
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [7:0]  MIN_RESET  = 8'd255;
  localparam logic [7:0]  MAX_RESET  = 8'd0;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_APPLY   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
    logic       frame_start;
  } cs_in_t;

  typedef struct packed {
    logic [7:0] stretched;
    logic       flat_range;
  } cs_out_t;

  typedef struct packed {
    logic load_measure;
    logic load_apply;
    logic mul;
    logic div_step;
    logic out_load;
  } cs_cmd_t;

  typedef struct packed {
    logic need_div;
  } cs_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/cs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_dp: contrast stretch datapath
// Min/max tracking, range capture, x255 product and an 8-step restoring
// divider, plus the result register.
// ----------------------------------------------------------------------------
module cs_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cs_pkg::cs_in_t  in_data,
  input  wire cs_pkg::cs_cmd_t cmd,
  output cs_pkg::cs_sts_t      sts,
  output cs_pkg::cs_out_t      out_data
);

  logic [7:0]  min_r, min_nxt;
  logic [7:0]  max_r, max_nxt;
  logic        flat_r;
  logic        use_div_r;
  logic [7:0]  sat_r;
  logic [7:0]  diff_r;
  logic [7:0]  den_r;
  logic [7:0]  rem_r;
  logic [7:0]  quo_r;
  cs_pkg::cs_out_t out_r;

  logic        flat;
  logic        below;
  logic        above;
  logic [15:0] prod;
  logic [8:0]  trial;
  logic        fits;
  logic [8:0]  trial_sub;

  assign flat  = (max_r <= min_r);
  assign below = (in_data.pixel <= min_r);
  assign above = (in_data.pixel >= max_r);
  assign sts.need_div = !flat && !below && !above;

  // diff * 255 as (diff << 8) - diff
  assign prod      = {diff_r, 8'd0} - {8'd0, diff_r};
  assign trial     = {rem_r, quo_r[7]};
  assign fits      = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (in_data.frame_start) begin
      min_nxt = in_data.pixel;
      max_nxt = in_data.pixel;
    end else begin
      if (in_data.pixel < min_r) min_nxt = in_data.pixel;
      if (in_data.pixel > max_r) max_nxt = in_data.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= cs_pkg::MIN_RESET;
      max_r <= cs_pkg::MAX_RESET;
    end else if (cmd.load_measure) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // capture the range at acceptance; later measures do not disturb it
  always_ff @(posedge clk) begin
    if (cmd.load_apply) begin
      flat_r    <= flat;
      use_div_r <= sts.need_div;
      sat_r     <= (flat || below) ? 8'd0 : cs_pkg::FULL_SCALE;
      diff_r    <= in_data.pixel - min_r;
      den_r     <= max_r - min_r;
    end
    if (cmd.mul) begin
      rem_r <= prod[15:8];
      quo_r <= prod[7:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? trial_sub[7:0] : trial[7:0];
      quo_r <= {quo_r[6:0], fits};
    end
    if (cmd.out_load) begin
      out_r.stretched  <= use_div_r ? quo_r : sat_r;
      out_r.flat_range <= flat_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/cs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cs_ctrl: contrast stretch controller
// Sequences accept, multiply, divide steps and result load; owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module cs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_func,
  input  wire logic            out_stall,
  input  wire cs_pkg::cs_sts_t sts,
  output logic                 in_stall,
  output logic                 out_valid,
  output cs_pkg::cs_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [cs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     accept;
  logic                     div_last;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign div_last = (cnt_r == cs_pkg::CNT_W'(cs_pkg::DIV_STEPS - 1));

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    cmd              = '0;
    cmd.load_measure = accept && (in_func == cs_pkg::FUNC_MEASURE);
    cmd.load_apply   = accept && (in_func == cs_pkg::FUNC_APPLY);
    case (state_r)
      ST_IDLE: begin
        if (cmd.load_apply) state_nxt = sts.need_div ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result slot is free or draining
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/contrast_stretch_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contrast_stretch_core: min/max linear contrast stretch
// Measure transactions fold pixels into the frame min/max; apply
// transactions return (pixel - min) * 255 / (max - min), saturated.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall  | cs_in_t  (func, pixel, frame_start)
//   out     | output    | out_valid / out_stall| cs_out_t (stretched, flat_range)
//
// A measure transaction leaves the controller idle. An apply transaction with a
// pixel outside (min, max) or an empty range loads its result directly; others
// pass the multiply and the restoring divider, one quotient bit per cycle.
// Synchronous active-low reset sets min to 255 and max to 0.
// A waiting result holds in the output register; only a second apply result
// finding that register full stalls the controller, and with it in_stall.
// ----------------------------------------------------------------------------
`include "contrast_stretch_core_macros.svh"

module contrast_stretch_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cs_pkg::cs_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output cs_pkg::cs_out_t      out_data
);

  cs_pkg::cs_cmd_t cmd;
  cs_pkg::cs_sts_t sts;

  cs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  `CS_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || !out_stall)
  `CS_ASSERT_NEXT(a_apply_busy, clk, rst_n,
    in_valid && !in_stall && (in_data.func == cs_pkg::FUNC_APPLY), in_stall)
  `CS_ASSERT_NOW(a_flat_zero, clk, rst_n,
    out_valid && out_data.flat_range, out_data.stretched == 8'd0)

endmodule
`default_nettype wire

>>> dv/contrast_stretch_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_stretch_core_tb: self-checking bench for the min/max contrast stretch
// A directed table covers the empty and flat ranges, both pixel extremes,
// saturation below min and above max, and frame restarts. Random frames
// follow: a restart, a run of measures, then a run of applies, mixed with
// stray transactions. Each apply result is checked field by field against its
// table row or a bench model of the frame min/max tracker. Both channels idle at
// random, and the receiver holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module contrast_stretch_core_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int IDLE_PCT       = 29;
  localparam int TX_QUIET_FROM  = 400;
  localparam int TX_QUIET_TO    = 650;
  localparam int RX_QUIET_FROM  = 250;
  localparam int RX_QUIET_TO    = 400;
  localparam int HOLD_AT_RESULT = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int N_DIRECTED     = 25;

  localparam bit CHECK_MODEL = 1'b0;
  localparam bit CHECK_TABLE = 1'b1;

  typedef struct packed {
    cs_pkg::cs_in_t  item;
    logic            typed;
    cs_pkg::cs_out_t want;
  } dir_row_t;

  // func, pixel, frame_start | check source, stretched, flat_range
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    {cs_pkg::FUNC_APPLY,   8'd0,   1'b0, CHECK_TABLE, 8'd0,   1'b1},  // nothing measured yet
    {cs_pkg::FUNC_APPLY,   8'd255, 1'b0, CHECK_TABLE, 8'd0,   1'b1},
    {cs_pkg::FUNC_APPLY,   8'd128, 1'b1, CHECK_TABLE, 8'd0,   1'b1},  // restart ignored on apply
    {cs_pkg::FUNC_MEASURE, 8'd100, 1'b1, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd100, 1'b0, CHECK_TABLE, 8'd0,   1'b1},  // flat range
    {cs_pkg::FUNC_MEASURE, 8'd0,   1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd255, 1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd0,   1'b0, CHECK_TABLE, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd255, 1'b0, CHECK_TABLE, 8'd255, 1'b0},
    {cs_pkg::FUNC_APPLY,   8'd128, 1'b0, CHECK_TABLE, 8'd128, 1'b0},  // full range is identity
    {cs_pkg::FUNC_APPLY,   8'd1,   1'b1, CHECK_TABLE, 8'd1,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd50,  1'b1, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd60,  1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd55,  1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd49,  1'b0, CHECK_TABLE, 8'd0,   1'b0},  // below min
    {cs_pkg::FUNC_APPLY,   8'd61,  1'b0, CHECK_TABLE, 8'd255, 1'b0},  // above max
    {cs_pkg::FUNC_APPLY,   8'd55,  1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd57,  1'b1, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd0,   1'b1, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd1,   1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd0,   1'b0, CHECK_TABLE, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd1,   1'b0, CHECK_TABLE, 8'd255, 1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd254, 1'b1, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_MEASURE, 8'd255, 1'b0, CHECK_MODEL, 8'd0,   1'b0},
    {cs_pkg::FUNC_APPLY,   8'd254, 1'b1, CHECK_TABLE, 8'd0,   1'b0}
  };

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  cs_pkg::cs_in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  cs_pkg::cs_out_t out_data;

  // model state: frame min/max as the block should hold them
  logic [7:0] frame_min = cs_pkg::MIN_RESET;
  logic [7:0] frame_max = cs_pkg::MAX_RESET;

  cs_pkg::cs_out_t expected_stretch_q[$];
  cs_pkg::cs_out_t oldest_expected;
  int      mismatches   = 0;
  int      results_seen = 0;
  int      random_sent  = 0;
  bit      sender_quiet = 1'b0;
  int      hold_left    = 0;
  bit      hold_done    = 1'b0;

  contrast_stretch_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Fold a measure into the frame min/max, or return 1 with the expected
  // stretch of an apply.
  function automatic bit predict_stretch(input cs_pkg::cs_in_t it,
                                         output cs_pkg::cs_out_t res);
    int unsigned num;
    int unsigned den;
    res = '0;
    if (it.func == cs_pkg::FUNC_MEASURE) begin
      if (it.frame_start) begin
        frame_min = it.pixel;
        frame_max = it.pixel;
      end else begin
        if (it.pixel < frame_min) frame_min = it.pixel;
        if (it.pixel > frame_max) frame_max = it.pixel;
      end
      return 1'b0;
    end
    if (frame_max <= frame_min) begin
      res.flat_range = 1'b1;  // also the case before any measure
    end else if (it.pixel >= frame_max) begin
      res.stretched = cs_pkg::FULL_SCALE;
    end else if (it.pixel > frame_min) begin
      num = (int'(it.pixel) - int'(frame_min)) * int'(cs_pkg::FULL_SCALE);
      den = int'(frame_max) - int'(frame_min);
      res.stretched = 8'(num / den);
    end
    return 1'b1;
  endfunction

  function automatic void report_mismatch(input string what, input cs_pkg::cs_out_t want,
                                          input cs_pkg::cs_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch (%s): expected stretched=%0d flat=%0b, got stretched=%0d flat=%0b",
               $time, what, want.stretched, want.flat_range, got.stretched, got.flat_range);
  endfunction

  // Offer one transaction, hold it until accepted, then log what it should yield.
  task automatic send_pixel(input cs_pkg::cs_in_t it, input bit typed,
                            input cs_pkg::cs_out_t want);
    cs_pkg::cs_out_t res;
    while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_stretch(it, res))
      expected_stretch_q.push_back(typed ? want : res);
  endtask

  initial begin : stimulus
    cs_pkg::cs_in_t it;
    int     lo;
    int     span;
    int     p;
    int     n_meas;
    int     n_apply;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    while (random_sent < RANDOM_ITEMS) begin
      sender_quiet = (random_sent >= TX_QUIET_FROM && random_sent < TX_QUIET_TO);
      if ($urandom_range(9) == 0) begin
        // stray transaction, every field random
        it.func        = 1'($urandom_range(1));
        it.pixel       = 8'($urandom_range(255));
        it.frame_start = 1'($urandom_range(1));
        send_pixel(it, CHECK_MODEL, '0);
        random_sent++;
      end else begin
        case ($urandom_range(9))
          0:       span = 0;
          1, 2, 3: span = $urandom_range(15, 1);
          default: span = $urandom_range(255, 1);
        endcase
        lo     = $urandom_range(255 - span);
        n_meas = $urandom_range(12, 1);
        for (int k = 0; k < n_meas; k++) begin
          it.func  = cs_pkg::FUNC_MEASURE;
          it.pixel = 8'($urandom_range(lo + span, lo));
          // restart on the first one, but now and then let the old frame run on
          it.frame_start = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(31) == 0);
          send_pixel(it, CHECK_MODEL, '0);
          random_sent++;
        end
        n_apply = $urandom_range(20, 1);
        for (int k = 0; k < n_apply; k++) begin
          it.func = cs_pkg::FUNC_APPLY;
          if ($urandom_range(4) == 0) begin
            p = $urandom_range(255);
          end else begin
            p = int'($urandom_range(span + 4)) + lo - 2;
            if (p < 0) p = 0;
            if (p > 255) p = 255;
          end
          it.pixel       = 8'(p);
          it.frame_start = 1'($urandom_range(1));
          send_pixel(it, CHECK_MODEL, '0);
          random_sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_stretch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Result side: check each result taken, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_stretch_q.size() == 0) begin
        report_mismatch("no result expected", '0, out_data);
      end else begin
        oldest_expected = expected_stretch_q.pop_front();
        if (out_data.stretched !== oldest_expected.stretched ||
            out_data.flat_range !== oldest_expected.flat_range)
          report_mismatch("field", oldest_expected, out_data);
      end
    end
    if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      // long hold-off: let the block fill and push back on its input
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen >= RX_QUIET_FROM && results_seen < RX_QUIET_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
